>>> rtl/core/hgf_pkg.sv
// ----------------------------------------------------------------------------
// hgf_pkg: shared types and constants of the haversine geofence check
// Datapath widths, CORDIC control types and the arctangent table in turns.
// ----------------------------------------------------------------------------
package hgf_pkg;

  // width of CORDIC x/y/z registers and of stored Q30 values
  localparam int unsigned DW = 34;
  // width of one multiplier operand
  localparam int unsigned MW = 33;
  // width of an index into the arctangent table
  localparam int unsigned IW = 5;

  // 1/K in Q30, the rotation start value
  localparam logic signed [DW-1:0] InvGain = 34'sd652032874;
  // circumference of the 6371 km sphere in metres, Q6
  localparam logic signed [MW-1:0] CircQ6 = 33'sd2561931110;
  // half circumference in whole metres, the distance ceiling
  localparam logic [24:0] HalfCircM = 25'd20015087;
  // 1.0 in Q30
  localparam logic [30:0] Q30One = 31'h4000_0000;

  typedef enum logic {
    CORDIC_ROTATE,
    CORDIC_VECTOR
  } cordic_mode_e;

  typedef struct packed {
    logic         start;
    cordic_mode_e mode;
  } cordic_ctrl_t;

  // atan(2^-i) in binary angle, 2^32 per full turn
  function automatic logic signed [DW-1:0] atan_turn(input logic [IW-1:0] idx);
    logic signed [DW-1:0] val;
    case (idx)
      5'd0:  val = 34'sd536870912;
      5'd1:  val = 34'sd316933406;
      5'd2:  val = 34'sd167458907;
      5'd3:  val = 34'sd85004756;
      5'd4:  val = 34'sd42667331;
      5'd5:  val = 34'sd21354465;
      5'd6:  val = 34'sd10679838;
      5'd7:  val = 34'sd5340245;
      5'd8:  val = 34'sd2670163;
      5'd9:  val = 34'sd1335087;
      5'd10: val = 34'sd667544;
      5'd11: val = 34'sd333772;
      5'd12: val = 34'sd166886;
      5'd13: val = 34'sd83443;
      5'd14: val = 34'sd41722;
      5'd15: val = 34'sd20861;
      5'd16: val = 34'sd10430;
      5'd17: val = 34'sd5215;
      5'd18: val = 34'sd2608;
      5'd19: val = 34'sd1304;
      5'd20: val = 34'sd652;
      5'd21: val = 34'sd326;
      5'd22: val = 34'sd163;
      5'd23: val = 34'sd81;
      5'd24: val = 34'sd41;
      5'd25: val = 34'sd20;
      5'd26: val = 34'sd10;
      5'd27: val = 34'sd5;
      5'd28: val = 34'sd3;
      5'd29: val = 34'sd1;
      5'd30: val = 34'sd1;
      default: val = 34'sd0;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/hgf_turn_div.sv
// ----------------------------------------------------------------------------
// hgf_turn_div: divide by 360 through reciprocal multiplication
// Multiplies the numerator by ceil(2^K/360) in 16-bit chunks, one chunk per
// cycle, and keeps the low 32 bits of the quotient.
// ----------------------------------------------------------------------------
module hgf_turn_div #(
  parameter int unsigned NUM_W = 43
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  output logic             done_o,
  output logic [31:0]      quot_o
);

  // exact floor for every NUM_W-bit numerator: error of the reciprocal < 2^9
  localparam int unsigned K   = NUM_W + 9;
  localparam int unsigned RW  = NUM_W + 1;
  localparam int unsigned CH  = 16;
  localparam int unsigned NCH = (RW + CH - 1) / CH;
  localparam int unsigned RPW = NCH * CH;
  localparam int unsigned AW  = NUM_W + RPW;
  localparam int unsigned CW  = $clog2(NCH);
  localparam logic [63:0]     Recip64 = ((64'd1 << K) + 64'd359) / 64'd360;
  localparam logic [RPW-1:0]  Recip   = RPW'(Recip64);

  logic [NUM_W-1:0]    num_q;
  logic [AW-1:0]       acc_q, acc_d;
  logic [CW-1:0]       cnt_q;
  logic                busy_q, done_q;
  logic [CH-1:0]       chunk;
  logic [NUM_W+CH-1:0] prod;

  // walk the reciprocal from its top chunk down
  assign chunk = Recip[cnt_q*CH +: CH];
  assign prod  = (NUM_W+CH)'(num_q) * (NUM_W+CH)'(chunk);
  assign acc_d = (acc_q << CH) + AW'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NCH - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = acc_q[K +: 32];

endmodule

>>> rtl/core/hgf_isqrt.sv
// ----------------------------------------------------------------------------
// hgf_isqrt: iterative integer square root
// Floor square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module hgf_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] arg_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] v_q, r_q, probe_q;
  logic [63:0] sum;
  logic        ge;
  logic        busy_q, done_q;

  assign sum = r_q + probe_q;
  assign ge  = v_q >= sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && probe_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q     <= arg_i;
      r_q     <= '0;
      probe_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      probe_q <= probe_q >> 2;
      if (ge) begin
        v_q <= v_q - sum;
        r_q <= (r_q >> 1) + probe_q;
      end else begin
        r_q <= r_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

>>> rtl/core/hgf_cordic.sv
// ----------------------------------------------------------------------------
// hgf_cordic: shared CORDIC unit
// One micro-rotation per cycle, rotation mode for sin/cos, vectoring for atan.
// ----------------------------------------------------------------------------
module hgf_cordic #(
  parameter int unsigned ITER = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  hgf_pkg::cordic_ctrl_t        ctrl_i,
  input  logic signed [hgf_pkg::DW-1:0] x_i,
  input  logic signed [hgf_pkg::DW-1:0] y_i,
  input  logic signed [hgf_pkg::DW-1:0] z_i,
  output logic                         done_o,
  output logic signed [hgf_pkg::DW-1:0] x_o,
  output logic signed [hgf_pkg::DW-1:0] y_o,
  output logic signed [hgf_pkg::DW-1:0] z_o
);

  localparam int unsigned CW = $clog2(ITER + 1);

  logic signed [hgf_pkg::DW-1:0] x_q, y_q, z_q, xs, ys, at;
  hgf_pkg::cordic_mode_e         mode_q;
  logic [CW-1:0]                 cnt_q;
  logic [hgf_pkg::IW-1:0]        idx;
  logic                          busy_q, done_q, sigma;

  assign idx   = cnt_q[hgf_pkg::IW-1:0];
  assign xs    = x_q >>> idx;
  assign ys    = y_q >>> idx;
  assign at    = hgf_pkg::atan_turn(idx);
  // turn counterclockwise when the residual says so
  assign sigma = (mode_q == hgf_pkg::CORDIC_ROTATE) ? !z_q[hgf_pkg::DW-1]
                                                    : y_q[hgf_pkg::DW-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      x_q    <= x_i;
      y_q    <= y_i;
      z_q    <= z_i;
      mode_q <= ctrl_i.mode;
    end else if (busy_q) begin
      if (sigma) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + at;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

>>> rtl/core/haversine_geofence_check_top.sv
// ----------------------------------------------------------------------------
// haversine_geofence_check_top: geofence check by great-circle distance
// Computes the haversine distance from a fix to a home point and flags fixes
// beyond the fence radius, using one divider, one CORDIC, one square root
// unit and one multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+-------------------------------
//  fix in   | in        | in_valid_i / in_stall_o | fix_latitude/longitude/valid
//  result   | out       | out_valid_o/out_stall_i | distance_m, fence_violated, recomputed
//  config   | in/out    | APB psel/penable/pready | 4 registers at 8*i, 64-bit data
//
// Flow: a recomputed fix passes the divide by 360 and the rotation of each of the
//   four angles, the haversine products, the two square roots, the vectoring and
//   the distance product; NCH = 3 reciprocal chunks of the divide by 360 at the
//   default angle width. A fix that is not recomputed goes from idle straight to
//   S_FIN and the output register; the sequencer then returns to idle for the next fix.
// Reset: rst_ni clears state, held distance and flag; radius resets to 1000.
// Stalls: one transaction is in work at a time; in_stall_o is high while busy.
//   A finished result waits in the output register while out_stall_i is high.
// ----------------------------------------------------------------------------
module haversine_geofence_check_top #(
  parameter int unsigned ANGLE_FRAC_BITS   = 24,
  parameter int unsigned CORDIC_ITERATIONS = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // fix channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] fix_latitude_i,
  input  logic signed [32:0] fix_longitude_i,
  input  logic               fix_valid_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [24:0]        distance_m_o,
  output logic               fence_violated_o,
  output logic               recomputed_o,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned DW    = hgf_pkg::DW;
  localparam int unsigned MW    = hgf_pkg::MW;
  localparam int unsigned PW    = 2 * MW;
  localparam int unsigned SH    = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned NUM_W = 35 + SH;

  localparam logic [1:0] RegEnable = 2'd0;
  localparam logic [1:0] RegHomeLat = 2'd1;
  localparam logic [1:0] RegHomeLon = 2'd2;
  localparam logic [1:0] RegRadius = 2'd3;

  localparam logic signed [PW-1:0] RndQ30  = PW'(64'sd536870912);
  localparam logic signed [PW-1:0] RndDist = PW'(64'sd68719476736);
  localparam logic signed [PW-1:0] HalfLim = PW'(hgf_pkg::HalfCircM);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DIVW, S_ROT, S_ROTW, S_MUL, S_SQ, S_SQW,
    S_VEC, S_VECW, S_DMUL, S_DRND, S_FIN
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic               fence_enable_q;
  logic signed [31:0] home_lat_q;
  logic signed [32:0] home_lon_q;
  logic [24:0]        radius_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fence_enable_q <= 1'b0;
      home_lat_q     <= '0;
      home_lon_q     <= '0;
      radius_q       <= 25'd1000;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        RegEnable:  fence_enable_q <= pwdata[0];
        RegHomeLat: home_lat_q     <= pwdata[31:0];
        RegHomeLon: home_lon_q     <= pwdata[32:0];
        RegRadius:  radius_q       <= pwdata[24:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      RegEnable:  prdata = 64'(fence_enable_q);
      RegHomeLat: prdata = {32'b0, home_lat_q};
      RegHomeLon: prdata = {31'b0, home_lon_q};
      RegRadius:  prdata = 64'(radius_q);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer state and datapath registers
  // --------------------------------------------------------------------------
  state_e               state_q;
  logic [1:0]           k_q;        // which angle: dlat, dlon, lat1, lat2
  logic [2:0]           mstep_q;    // product step of the haversine term
  logic                 sq_sel_q;   // 0: sqrt(a), 1: sqrt(1-a)
  logic                 neg_q, fold_q, rec_q;
  logic [24:0]          held_distance_q;
  logic                 held_violation_q;
  logic                 out_valid_q;

  logic signed [31:0]   fix_lat_q;
  logic signed [32:0]   fix_lon_q;
  logic [31:0]          turn_q;
  logic signed [DW-1:0] s_lat_q, s_lon_q, c1_q, c2_q;
  logic signed [DW-1:0] t_a_q, t_c_q, t_s_q, z_fin_q;
  logic [30:0]          a_q;
  logic [31:0]          sq_y_q, sq_x_q;
  logic signed [PW-1:0] prod_q;
  logic [24:0]          out_dist_q;
  logic                 out_viol_q, out_rec_q;

  logic in_acc, out_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // output register can take a result this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // Angle conversion: degrees * 2^F to binary turns
  // --------------------------------------------------------------------------
  logic signed [33:0]   ang_src;
  logic [33:0]          ang_mag;
  logic [NUM_W-1:0]     div_num;
  logic                 div_start, div_done;
  logic [31:0]          div_quot;

  always_comb begin
    case (k_q)
      2'd0:    ang_src = {home_lat_q[31], home_lat_q[31], home_lat_q}
                       - {fix_lat_q[31], fix_lat_q[31], fix_lat_q};
      2'd1:    ang_src = {home_lon_q[32], home_lon_q} - {fix_lon_q[32], fix_lon_q};
      2'd2:    ang_src = {fix_lat_q[31], fix_lat_q[31], fix_lat_q};
      default: ang_src = {home_lat_q[31], home_lat_q[31], home_lat_q};
    endcase
  end

  assign ang_mag   = ang_src[33] ? 34'(-ang_src) : 34'(ang_src);
  // round to nearest: add half the divisor before the division
  assign div_num   = (NUM_W'(ang_mag) << SH) + NUM_W'(180);
  assign div_start = (state_q == S_DIV);

  hgf_turn_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // --------------------------------------------------------------------------
  // Shared CORDIC: sin/cos of the four angles, then atan2 of the roots
  // --------------------------------------------------------------------------
  logic [31:0]          rot_u, rot_sum, rot_u2;
  logic                 rot_fold;
  hgf_pkg::cordic_ctrl_t cor_ctrl;
  logic signed [DW-1:0] cor_x_in, cor_y_in, cor_z_in;
  logic signed [DW-1:0] cor_x, cor_y, cor_z;
  logic                 cor_done;

  // halve the difference angles, keep the absolute latitudes whole
  assign rot_u    = k_q[1] ? turn_q : {1'b0, turn_q[31:1]};
  assign rot_sum  = rot_u + 32'h4000_0000;
  // fold the angle into the right half plane
  assign rot_fold = rot_sum[31];
  assign rot_u2   = rot_fold ? rot_u + 32'h8000_0000 : rot_u;

  always_comb begin
    cor_ctrl.start = 1'b0;
    cor_ctrl.mode  = hgf_pkg::CORDIC_ROTATE;
    cor_x_in       = hgf_pkg::InvGain;
    cor_y_in       = '0;
    cor_z_in       = {rot_u2[31], rot_u2[31], rot_u2};
    if (state_q == S_ROT) begin
      cor_ctrl.start = 1'b1;
    end else if (state_q == S_VEC) begin
      cor_ctrl.start = 1'b1;
      cor_ctrl.mode  = hgf_pkg::CORDIC_VECTOR;
      cor_x_in       = DW'(sq_x_q);
      cor_y_in       = DW'(sq_y_q);
      cor_z_in       = '0;
    end
  end

  hgf_cordic #(
    .ITER (CORDIC_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (cor_ctrl),
    .x_i    (cor_x_in),
    .y_i    (cor_y_in),
    .z_i    (cor_z_in),
    .done_o (cor_done),
    .x_o    (cor_x),
    .y_o    (cor_y),
    .z_o    (cor_z)
  );

  // --------------------------------------------------------------------------
  // Square roots of a and 1-a, Q30
  // --------------------------------------------------------------------------
  logic [63:0] sq_arg;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;

  assign sq_arg   = sq_sel_q ? (64'(31'(hgf_pkg::Q30One - a_q)) << 30)
                             : (64'(a_q) << 30);
  assign sq_start = (state_q == S_SQ);

  hgf_isqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (sq_arg),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // --------------------------------------------------------------------------
  // Shared multiplier, product registered before rounding
  // --------------------------------------------------------------------------
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] rnd_full, dist_full;
  logic signed [DW-1:0] q30;
  logic signed [DW:0]   a_sum;
  logic [24:0]          dist_new;

  always_comb begin
    case (mstep_q)
      3'd0: begin
        mul_a = s_lon_q[MW-1:0];
        mul_b = s_lon_q[MW-1:0];
      end
      3'd1: begin
        mul_a = c1_q[MW-1:0];
        mul_b = c2_q[MW-1:0];
      end
      3'd2: begin
        mul_a = s_lat_q[MW-1:0];
        mul_b = s_lat_q[MW-1:0];
      end
      3'd3: begin
        mul_a = t_c_q[MW-1:0];
        mul_b = t_s_q[MW-1:0];
      end
      default: begin
        mul_a = z_fin_q[MW-1:0];
        mul_b = hgf_pkg::CircQ6;
      end
    endcase
    if (state_q == S_DMUL) begin
      mul_a = z_fin_q[MW-1:0];
      mul_b = hgf_pkg::CircQ6;
    end
  end

  assign rnd_full  = (prod_q + RndQ30) >>> 30;
  assign q30       = rnd_full[DW-1:0];
  assign a_sum     = {t_a_q[DW-1], t_a_q} + {q30[DW-1], q30};
  assign dist_full = (prod_q + RndDist) >>> 37;

  always_comb begin
    if (z_fin_q[DW-1] || (z_fin_q == '0)) begin
      dist_new = '0;
    end else if (dist_full > HalfLim) begin
      dist_new = hgf_pkg::HalfCircM;
    end else begin
      dist_new = dist_full[24:0];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= S_IDLE;
      k_q              <= '0;
      mstep_q          <= '0;
      sq_sel_q         <= 1'b0;
      rec_q            <= 1'b0;
      held_distance_q  <= '0;
      held_violation_q <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      // drop the result once the consumer takes it, unless a new one replaces it
      if (out_valid_q && !out_stall_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            k_q   <= '0;
            rec_q <= 1'b0;
            if (fence_enable_q && fix_valid_i) begin
              state_q <= S_DIV;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_DIV:  state_q <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            state_q <= S_ROT;
          end
        end
        S_ROT:  state_q <= S_ROTW;
        S_ROTW: begin
          if (cor_done) begin
            if (k_q == 2'd3) begin
              mstep_q <= '0;
              state_q <= S_MUL;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_DIV;
            end
          end
        end
        S_MUL: begin
          mstep_q <= mstep_q + 1'b1;
          if (mstep_q == 3'd4) begin
            sq_sel_q <= 1'b0;
            state_q  <= S_SQ;
          end
        end
        S_SQ:   state_q <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            if (sq_sel_q) begin
              state_q <= S_VEC;
            end else begin
              sq_sel_q <= 1'b1;
              state_q  <= S_SQ;
            end
          end
        end
        S_VEC:  state_q <= S_VECW;
        S_VECW: begin
          if (cor_done) begin
            state_q <= S_DMUL;
          end
        end
        S_DMUL: state_q <= S_DRND;
        S_DRND: begin
          held_distance_q  <= dist_new;
          held_violation_q <= dist_new > radius_q;
          rec_q            <= 1'b1;
          state_q          <= S_FIN;
        end
        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fix_lat_q <= fix_latitude_i;
      fix_lon_q <= fix_longitude_i;
    end
    if (state_q == S_DIV) begin
      neg_q <= ang_src[33];
    end
    if (state_q == S_DIVW && div_done) begin
      turn_q <= neg_q ? 32'(32'd0 - div_quot) : div_quot;
    end
    if (state_q == S_ROT) begin
      fold_q <= rot_fold;
    end
    if (state_q == S_ROTW && cor_done) begin
      case (k_q)
        2'd0:    s_lat_q <= fold_q ? -cor_y : cor_y;
        2'd1:    s_lon_q <= fold_q ? -cor_y : cor_y;
        2'd2:    c1_q    <= fold_q ? -cor_x : cor_x;
        default: c2_q    <= fold_q ? -cor_x : cor_x;
      endcase
    end
    if ((state_q == S_MUL && mstep_q != 3'd4) || state_q == S_DMUL) begin
      prod_q <= mul_a * mul_b;
    end
    if (state_q == S_MUL) begin
      case (mstep_q)
        3'd1: t_s_q <= q30;
        3'd2: t_c_q <= q30;
        3'd3: t_a_q <= q30;
        3'd4: begin
          // clamp a to [0, 1]
          if (a_sum[DW]) begin
            a_q <= '0;
          end else if (a_sum > (DW+1)'(hgf_pkg::Q30One)) begin
            a_q <= hgf_pkg::Q30One;
          end else begin
            a_q <= a_sum[30:0];
          end
        end
        default: ;
      endcase
    end
    if (state_q == S_SQW && sq_done) begin
      if (sq_sel_q) begin
        sq_x_q <= sq_root;
      end else begin
        sq_y_q <= sq_root;
      end
    end
    if (state_q == S_VECW && cor_done) begin
      z_fin_q <= cor_z;
    end
    if (state_q == S_FIN && out_free) begin
      out_dist_q <= held_distance_q;
      out_viol_q <= fence_enable_q && held_violation_q;
      out_rec_q  <= rec_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_m_o     = out_dist_q;
  assign fence_violated_o = out_viol_q;
  assign recomputed_o     = out_rec_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_dist_ceiling: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> distance_m_o <= hgf_pkg::HalfCircM)
    else $error("distance above half circumference");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIVW)
    else $error("divider finished outside its wait state");

  a_cordic_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cor_done |-> (state_q == S_ROTW || state_q == S_VECW))
    else $error("CORDIC finished outside its wait states");

  a_sqrt_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_SQW)
    else $error("square root finished outside its wait state");

  a_hav_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SQ |-> a_q <= hgf_pkg::Q30One)
    else $error("haversine term out of range");

endmodule
